@@ rtl/key_matrix_scan_with_ghosting_defines.svh @@
// ---------------------------------------------------------------------------
// key matrix scanner assertion macros
// shared property wrappers for the scanner's concurrent checks
// ---------------------------------------------------------------------------
`ifndef KEY_MATRIX_SCAN_WITH_GHOSTING_DEFINES_SVH
`define KEY_MATRIX_SCAN_WITH_GHOSTING_DEFINES_SVH

// same-cycle implication, quiet during reset
`define KMS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, quiet during reset
`define KMS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/kms_pkg.sv @@
// ---------------------------------------------------------------------------
// kms_pkg
// types and constants shared by the key matrix scanner modules
// ---------------------------------------------------------------------------
package kms_pkg;

   localparam int unsigned LINES = 8;

   // ghost closure rounds after the initial one-hop load
   localparam int unsigned CLOSE_ROUNDS = LINES - 2;

   localparam logic [9:0] REG10_MASK  = 10'h3FF;
   localparam logic [5:0] POWER_KEY   = 6'd63;
   localparam logic [7:0] SENSE_IDLE  = 8'hFF;
   localparam logic [7:0] SENSE7_PULL = 8'h7F;

   // request kinds carried in tuser
   localparam logic [1:0] MODE_KEY   = 2'd0;
   localparam logic [1:0] MODE_WRITE = 2'd1;
   localparam logic [1:0] MODE_READ  = 2'd2;
   localparam logic [1:0] MODE_TICK  = 2'd3;

   // register offsets
   localparam logic [2:0] OFF_SENSE    = 3'd0;
   localparam logic [2:0] OFF_MASK_LO  = 3'd4;
   localparam logic [2:0] OFF_MASK_HI  = 3'd5;
   localparam logic [2:0] OFF_DRIVE_LO = 3'd6;
   localparam logic [2:0] OFF_DRIVE_HI = 3'd7;

   // configuration indexes
   localparam logic [1:0] CSR_PIN_ZERO = 2'd0;
   localparam logic [1:0] CSR_PIN_ONE  = 2'd1;
   localparam logic [1:0] CSR_TEST_PIN = 2'd2;

   // [drive line][sense line]
   typedef logic [LINES-1:0][LINES-1:0] key_map_type;
   // [drive line] -> set of drive lines in the same component
   typedef logic [LINES-1:0][LINES-1:0] ghost_map_type;

   typedef struct packed {
      logic busy;
      logic done;
   } ghost_status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_KEY,
      ST_GHOST,
      ST_SENSE,
      ST_OUT
   } kms_state_type;

endpackage

@@ rtl/key_matrix_scan_with_ghosting.sv @@
// ---------------------------------------------------------------------------
// key_matrix_scan_with_ghosting
// 8x8 key matrix scanner with ghosting, drive/mask registers and pending irq
// ---------------------------------------------------------------------------
//  channel | direction | handshake               | payload
//  req     | in        | req_tvalid / req_tready  | req_tuser mode, req_tdata fields
//  rsp     | out       | rsp_tvalid / rsp_tready  | rsp_tdata read, sense, irq
//  csr     | in        | csr_valid / csr_ready    | csr_index, csr_wdata
//
// a key event that changes the map goes through the key, ghost and sense states;
// its ghost wait is set by the shared unit's closure rounds (load plus six rounds)
// low-byte drive and mask writes pass the sense state; all other words go to output
// req_tready is high only while idle; one word is worked on at a time
// a stalled result word waits in the output register and holds the sequencer
// reset is synchronous; it clears the key map, registers and sense to idle
// ---------------------------------------------------------------------------
`include "key_matrix_scan_with_ghosting_defines.svh"

module key_matrix_scan_with_ghosting (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [5:0] key_index, [6] key_down, [9:7] reg_offset, [17:10] write_byte,
   // [18] irq_taken, [23:19] zero
   input  logic [23:0] req_tdata,
   // [1:0] mode
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [7:0] read_byte, [15:8] sense_byte, [16] irq_request, [23:17] zero
   output logic [23:0] rsp_tdata,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic        csr_wdata
);
   import kms_pkg::*;

   // request fields
   logic [5:0] key_index;
   logic       key_down;
   logic [2:0] reg_offset;
   logic [7:0] write_byte;
   logic       irq_taken;
   logic [2:0] key_drive;
   logic [2:0] key_sense;

   assign key_index  = req_tdata[5:0];
   assign key_down   = req_tdata[6];
   assign reg_offset = req_tdata[9:7];
   assign write_byte = req_tdata[17:10];
   assign irq_taken  = req_tdata[18];
   assign key_drive  = key_index[5:3];
   assign key_sense  = key_index[2:0];

   kms_state_type state_ff, state_in;
   key_map_type   key_map_ff, key_map_in;
   logic [9:0]    drive_ff, drive_in;
   logic [9:0]    mask_ff, mask_in;
   logic [7:0]    sense_ff, sense_in;
   logic          pend_ff, pend_in;
   logic          pin_zero_ff, pin_zero_in;
   logic          pin_one_ff, pin_one_in;
   logic          test_pin_ff, test_pin_in;
   logic [7:0]    rd_ff, rd_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [23:0]   rsp_data_ff, rsp_data_in;

   logic          req_fire;
   logic          key_change;
   logic          ghost_start;
   ghost_status_type ghost_status;
   ghost_map_type ghost_groups;

   // sense recompute
   logic [9:0]    active;
   logic [7:0]    ghosted;
   logic [7:0]    pulled;
   logic [7:0]    sense_new;

   assign req_tready  = (state_ff == ST_IDLE);
   assign req_fire    = req_tvalid && req_tready;
   assign csr_ready   = 1'b1;
   assign ghost_start = (state_ff == ST_KEY);
   assign key_change  = (key_index != POWER_KEY) &&
                        (key_map_ff[key_drive][key_sense] != key_down);

   kms_ghost_unit u_ghost (
      .clock  (clock),
      .reset  (reset),
      .start  (ghost_start),
      .keys   (key_map_ff),
      .status (ghost_status),
      .groups (ghost_groups)
   );

   // active-low sense from the ghosted drive lines; lines 7..9 only reach
   // sense bit 7 through their pin settings
   always_comb begin
      active  = drive_ff & ~mask_ff & REG10_MASK;
      ghosted = '0;
      for (int i = 0; i < LINES - 1; i++) begin
         if (active[i]) begin
            ghosted = ghosted | ghost_groups[i];
         end
      end
      pulled = '0;
      for (int d = 0; d < LINES; d++) begin
         if (ghosted[d]) begin
            pulled = pulled | key_map_ff[d];
         end
      end
      sense_new = ~pulled;
      if ((active[7] && pin_zero_ff) || (active[8] && pin_one_ff) ||
          (active[9] && test_pin_ff)) begin
         sense_new = sense_new & SENSE7_PULL;
      end
   end

   // sequencer and register updates
   always_comb begin
      state_in     = state_ff;
      key_map_in   = key_map_ff;
      drive_in     = drive_ff;
      mask_in      = mask_ff;
      sense_in     = sense_ff;
      pend_in      = pend_ff;
      rd_in        = rd_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      pin_zero_in  = pin_zero_ff;
      pin_one_in   = pin_one_ff;
      test_pin_in  = test_pin_ff;

      if (csr_valid) begin
         unique case (csr_index)
            CSR_PIN_ZERO: pin_zero_in = csr_wdata;
            CSR_PIN_ONE:  pin_one_in  = csr_wdata;
            CSR_TEST_PIN: test_pin_in = csr_wdata;
            default:      ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               rd_in    = '0;
               state_in = ST_OUT;
               unique case (req_tuser)
                  MODE_KEY: begin
                     if (key_change) begin
                        key_map_in[key_drive][key_sense] = key_down;
                        pend_in  = 1'b1;
                        state_in = ST_KEY;
                     end
                  end
                  MODE_WRITE: begin
                     unique case (reg_offset)
                        OFF_MASK_LO: begin
                           mask_in  = {mask_ff[9:8], write_byte};
                           state_in = ST_SENSE;
                        end
                        OFF_MASK_HI: mask_in = {write_byte[1:0], mask_ff[7:0]};
                        OFF_DRIVE_LO: begin
                           drive_in = {drive_ff[9:8], write_byte};
                           state_in = ST_SENSE;
                        end
                        OFF_DRIVE_HI: drive_in = {write_byte[1:0], drive_ff[7:0]};
                        default: ;
                     endcase
                  end
                  MODE_READ: begin
                     unique case (reg_offset)
                        OFF_SENSE:    rd_in = sense_ff;
                        OFF_MASK_LO:  rd_in = mask_ff[7:0];
                        OFF_MASK_HI:  rd_in = {6'b0, mask_ff[9:8]};
                        OFF_DRIVE_LO: rd_in = drive_ff[7:0];
                        OFF_DRIVE_HI: rd_in = {6'b0, drive_ff[9:8]};
                        default:      rd_in = '0;
                     endcase
                  end
                  MODE_TICK: begin
                     if (irq_taken) begin
                        pend_in = 1'b0;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_KEY: begin
            // ghost unit latches adjacency this cycle
            state_in = ST_GHOST;
         end
         ST_GHOST: begin
            if (ghost_status.done) begin
               state_in = ST_SENSE;
            end
         end
         ST_SENSE: begin
            sense_in = sense_new;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {7'b0, pend_ff, sense_ff, rd_ff};
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         key_map_ff   <= '0;
         drive_ff     <= '0;
         mask_ff      <= '0;
         sense_ff     <= SENSE_IDLE;
         pend_ff      <= 1'b0;
         pin_zero_ff  <= 1'b0;
         pin_one_ff   <= 1'b0;
         test_pin_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         key_map_ff   <= key_map_in;
         drive_ff     <= drive_in;
         mask_ff      <= mask_in;
         sense_ff     <= sense_in;
         pend_ff      <= pend_in;
         pin_zero_ff  <= pin_zero_in;
         pin_one_ff   <= pin_one_in;
         test_pin_ff  <= test_pin_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      rd_ff       <= rd_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // power key never enters the map
   `KMS_ASSERT_NOW(a_power_key_clear, clock, reset, 1'b1, !key_map_ff[7][7],
      "power key position set in key map")
   // closure finishes only while the sequencer waits for it
   `KMS_ASSERT_NOW(a_done_in_ghost, clock, reset, ghost_status.done,
      state_ff == ST_GHOST, "ghost unit done outside ghost wait")
   // no closure in flight while taking new words
   `KMS_ASSERT_NOW(a_idle_not_busy, clock, reset, state_ff == ST_IDLE,
      !ghost_status.busy, "ghost unit busy while idle")
   // pending irq rises only on an accepted key change
   `KMS_ASSERT_NEXT(a_pend_source, clock, reset,
      !pend_ff && !(req_fire && req_tuser == MODE_KEY && key_change),
      !pend_ff, "irq pending set without key change")

endmodule

@@ rtl/kms_ghost_unit.sv @@
// ---------------------------------------------------------------------------
// kms_ghost_unit
// iterative connected-component closure of drive lines sharing pressed keys
// ---------------------------------------------------------------------------
module kms_ghost_unit (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  kms_pkg::key_map_type      keys,
   output kms_pkg::ghost_status_type status,
   output kms_pkg::ghost_map_type    groups
);
   import kms_pkg::*;

   localparam int unsigned STEP_W = $clog2(CLOSE_ROUNDS);

   ghost_map_type conn_ff, conn_in;
   ghost_map_type ghost_ff, ghost_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic load_ff, load_in;
   logic run_ff, run_in;
   logic done;

   // one-hop adjacency: lines c and a both press a key on some sense line
   always_comb begin
      for (int c = 0; c < LINES; c++) begin
         for (int a = 0; a < LINES; a++) begin
            conn_in[c][a] = |(keys[c] & keys[a]);
         end
      end
   end

   always_comb begin
      logic [LINES-1:0] grp;
      grp      = '0;
      done     = run_ff && (step_ff == STEP_W'(CLOSE_ROUNDS - 1));
      ghost_in = ghost_ff;
      step_in  = step_ff;
      load_in  = 1'b0;
      run_in   = run_ff;
      if (start) begin
         load_in = 1'b1;
      end
      if (load_ff) begin
         for (int c = 0; c < LINES; c++) begin
            ghost_in[c] = conn_ff[c] | (LINES'(1) << c);
         end
         step_in = '0;
         run_in  = 1'b1;
      end else if (run_ff) begin
         // one propagation round, all lines in parallel
         for (int c = 0; c < LINES; c++) begin
            grp = ghost_ff[c];
            for (int v = 0; v < LINES; v++) begin
               if (ghost_ff[c][v]) begin
                  grp = grp | conn_ff[v];
               end
            end
            ghost_in[c] = grp;
         end
         step_in = step_ff + STEP_W'(1);
         if (done) begin
            run_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < LINES; c++) begin
            ghost_ff[c] <= LINES'(1) << c;
         end
         step_ff <= '0;
         load_ff <= 1'b0;
         run_ff  <= 1'b0;
      end else begin
         ghost_ff <= ghost_in;
         step_ff  <= step_in;
         load_ff  <= load_in;
         run_ff   <= run_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         conn_ff <= conn_in;
      end
   end

   assign status.busy = load_ff | run_ff;
   assign status.done = done;
   assign groups      = ghost_ff;

endmodule

@@ tb/sv/key_matrix_scan_with_ghosting_test.sv @@
// ---------------------------------------------------------------------------
// key_matrix_scan_with_ghosting_test
// self-checking bench for the key matrix scanner: a cycle-free model of the
// key map, ghost components, drive/mask registers and pending irq works out
// each result word; directed register, key and pin cases, an output stall
// that backs up the request side, then random traffic under several pin
// settings with bursty requests and a stalling receiver
// ---------------------------------------------------------------------------
module key_matrix_scan_with_ghosting_test;
   timeunit 1ns;
   timeprecision 1ps;

   import kms_pkg::*;

   // generous bound for ~1700 words at worst-case gaps and stalls
   localparam int unsigned CYCLE_LIMIT = 600000;
   localparam int unsigned PRINT_LIMIT = 40;

   typedef struct packed {
      logic [1:0] mode;
      logic [5:0] key_index;
      logic       key_down;
      logic [2:0] reg_offset;
      logic [7:0] write_byte;
      logic       irq_taken;
   } scan_req_type;

   typedef struct packed {
      logic [7:0] read_byte;
      logic [7:0] sense_byte;
      logic       irq_request;
   } scan_rsp_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata  = '0;
   logic [1:0]  req_tuser  = MODE_KEY;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index  = CSR_PIN_ZERO;
   logic        csr_wdata  = 1'b0;

   // scanner model state
   logic [63:0] pressed_keys = '0;
   logic [9:0]  drive_reg    = '0;
   logic [9:0]  mask_reg     = '0;
   logic [7:0]  line_group [8];
   logic [7:0]  sense_reg    = SENSE_IDLE;
   logic        irq_pending  = 1'b0;
   logic [2:0]  pin_level    = '0;

   // result words still owed by the block, oldest first
   scan_rsp_type scan_reports_q [$];
   scan_rsp_type oldest_report;

   int unsigned cycle_count   = 0;
   int unsigned error_count   = 0;
   int          burst_left    = 0;
   bit          offering      = 1'b0;
   int          hold_request  = 0;
   int          hold_left     = 0;
   int          stall_style   = 0;
   int          style_left    = 0;

   key_matrix_scan_with_ghosting DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial forever #5 clock = ~clock;

   // run bound
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // printing stops after a while, counting does not
   task automatic report_mismatch(input string what, input logic [23:0] got,
                                  input logic [23:0] want);
      if (error_count < PRINT_LIMIT)
         $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $time);
      error_count++;
   endtask

   // ------------------------------------------------------------------
   // scanner model
   // ------------------------------------------------------------------

   // active lines 0..6 pull in their whole component; lines 7..9 only
   // act through the pin levels on sense bit 7
   function automatic void calc_sense();
      logic [9:0] active;
      logic [7:0] ghosted;
      int i, k;
      active  = drive_reg & ~mask_reg & REG10_MASK;
      ghosted = '0;
      for (i = 0; i < 7; i++)
         if (active[i]) ghosted |= line_group[i];
      sense_reg = SENSE_IDLE;
      for (k = 0; k < 63; k++)
         if (pressed_keys[k] && ghosted[k / 8]) sense_reg[k % 8] = 1'b0;
      if (active[7] && pin_level[CSR_PIN_ZERO]) sense_reg &= SENSE7_PULL;
      if (active[8] && pin_level[CSR_PIN_ONE])  sense_reg &= SENSE7_PULL;
      if (active[9] && pin_level[CSR_TEST_PIN]) sense_reg &= SENSE7_PULL;
   endfunction

   // two drive lines join when both hold a pressed key on one sense line;
   // components are the transitive closure of that relation
   function automatic void regroup_lines();
      logic [7:0] reach [8];
      logic [7:0] grp;
      int c, r, a, n, v;
      for (c = 0; c < 8; c++) begin
         reach[c] = '0;
         for (r = 0; r < 8; r++)
            if (pressed_keys[c * 8 + r])
               for (a = 0; a < 8; a++)
                  if (pressed_keys[a * 8 + r]) reach[c][a] = 1'b1;
      end
      for (c = 0; c < 8; c++) begin
         grp    = '0;
         grp[c] = 1'b1;
         for (n = 0; n < 8; n++)
            for (v = 0; v < 8; v++)
               if (grp[v]) grp |= reach[v];
         line_group[c] = grp;
      end
      irq_pending = 1'b1;
      calc_sense();
   endfunction

   // applies one accepted word and queues the result word it owes
   function automatic void scan_step(input scan_req_type w);
      scan_rsp_type r;
      r.read_byte = '0;
      case (w.mode)
         MODE_KEY: begin
            if (w.key_index != POWER_KEY && pressed_keys[w.key_index] != w.key_down) begin
               pressed_keys[w.key_index] = w.key_down;
               regroup_lines();
            end
         end
         MODE_WRITE: begin
            case (w.reg_offset)
               OFF_MASK_LO: begin
                  mask_reg[7:0] = w.write_byte;
                  calc_sense();
               end
               OFF_MASK_HI:  mask_reg[9:8] = w.write_byte[1:0];
               OFF_DRIVE_LO: begin
                  drive_reg[7:0] = w.write_byte;
                  calc_sense();
               end
               OFF_DRIVE_HI: drive_reg[9:8] = w.write_byte[1:0];
               default: ;
            endcase
         end
         MODE_READ: begin
            case (w.reg_offset)
               OFF_SENSE:    r.read_byte = sense_reg;
               OFF_MASK_LO:  r.read_byte = mask_reg[7:0];
               OFF_MASK_HI:  r.read_byte = {6'b0, mask_reg[9:8]};
               OFF_DRIVE_LO: r.read_byte = drive_reg[7:0];
               OFF_DRIVE_HI: r.read_byte = {6'b0, drive_reg[9:8]};
               default:      r.read_byte = '0;
            endcase
         end
         default: begin
            if (irq_pending && w.irq_taken) irq_pending = 1'b0;
         end
      endcase
      r.sense_byte  = sense_reg;
      r.irq_request = irq_pending;
      scan_reports_q.push_back(r);
   endfunction

   function automatic scan_req_type make_scan(input logic [1:0] mode, input logic [5:0] key,
                                              input logic down, input logic [2:0] off,
                                              input logic [7:0] data, input logic taken);
      scan_req_type w;
      w.mode       = mode;
      w.key_index  = key;
      w.key_down   = down;
      w.reg_offset = off;
      w.write_byte = data;
      w.irq_taken  = taken;
      return w;
   endfunction

   // ------------------------------------------------------------------
   // request side
   // ------------------------------------------------------------------

   // offers one word until taken; valid stays up inside a burst and drops
   // for a random gap when the burst runs out
   task automatic send_scan(input scan_req_type w);
      req_tvalid <= 1'b1;
      req_tuser  <= w.mode;
      req_tdata  <= {5'b0, w.irq_taken, w.write_byte, w.reg_offset, w.key_down, w.key_index};
      offering    = 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      scan_step(w);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_tvalid <= 1'b0;
         offering    = 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         // long bursts now and then give stretches with no gaps
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(0, 8);
      end
   endtask

   // stop offering and wait for every owed word
   task automatic settle();
      if (offering) begin
         req_tvalid <= 1'b0;
         offering    = 1'b0;
      end
      while (scan_reports_q.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   // writes all three pin registers back to back; block must be idle
   task automatic set_pins(input logic [2:0] levels);
      logic [1:0] order [3];
      int n;
      order = '{CSR_PIN_ZERO, CSR_PIN_ONE, CSR_TEST_PIN};
      for (n = 0; n < 3; n++) begin
         csr_valid <= 1'b1;
         csr_index <= order[n];
         csr_wdata <= levels[order[n]];
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
         pin_level[order[n]] = levels[order[n]];
      end
      csr_valid <= 1'b0;
   endtask

   // ------------------------------------------------------------------
   // result side
   // ------------------------------------------------------------------

   // receiver stall pattern: free running, random, periodic or mostly
   // stalled, switching pattern at random times; a requested hold wins
   always @(posedge clock) begin
      if (hold_request != 0) begin
         hold_left    = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         if (style_left == 0) begin
            stall_style = $urandom_range(0, 3);
            style_left  = $urandom_range(20, 200);
         end
         style_left--;
         case (stall_style)
            0:       rsp_tready <= 1'b1;
            1:       rsp_tready <= ($urandom_range(0, 99) < 70);
            2:       rsp_tready <= (cycle_count % 4 != 0);
            default: rsp_tready <= ($urandom_range(0, 99) < 25);
         endcase
      end
   end

   // every taken result word against the oldest owed one
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (scan_reports_q.size() == 0) begin
            report_mismatch("word with none owed", rsp_tdata, '0);
         end else begin
            oldest_report = scan_reports_q.pop_front();
            if (rsp_tdata[7:0] !== oldest_report.read_byte)
               report_mismatch("read_byte", 24'(rsp_tdata[7:0]),
                               24'(oldest_report.read_byte));
            if (rsp_tdata[15:8] !== oldest_report.sense_byte)
               report_mismatch("sense_byte", 24'(rsp_tdata[15:8]),
                               24'(oldest_report.sense_byte));
            if (rsp_tdata[16] !== oldest_report.irq_request)
               report_mismatch("irq_request", 24'(rsp_tdata[16]),
                               24'(oldest_report.irq_request));
         end
      end
   end

   // ------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------

   // drive registers, ignored sense and undecoded writes, every read offset
   task automatic test_register_map();
      logic [2:0] off;
      int n;
      send_scan(make_scan(MODE_WRITE, '0, 1'b0, OFF_DRIVE_LO, 8'hFF, 1'b0));
      // upper bits beyond line 9 must drop
      send_scan(make_scan(MODE_WRITE, '0, 1'b0, OFF_DRIVE_HI, 8'hFF, 1'b0));
      send_scan(make_scan(MODE_WRITE, '0, 1'b0, OFF_SENSE, 8'h00, 1'b0));
      for (off = OFF_SENSE + 3'd1; off < OFF_MASK_LO; off++)
         send_scan(make_scan(MODE_WRITE, '1, 1'b1, off, 8'hAA, 1'b1));
      for (n = 0; n < 8; n++)
         send_scan(make_scan(MODE_READ, '0, 1'b0, n[2:0], 8'h00, 1'b0));
   endtask

   // corner keys, ghost join, power key, unchanged key, irq acknowledge
   task automatic test_key_events();
      send_scan(make_scan(MODE_KEY, 6'd0, 1'b1, OFF_SENSE, 8'h00, 1'b0));
      // same sense line on drive line 1 joins lines 0 and 1
      send_scan(make_scan(MODE_KEY, 6'd8, 1'b1, OFF_SENSE, 8'h00, 1'b0));
      send_scan(make_scan(MODE_KEY, 6'd62, 1'b1, OFF_SENSE, 8'h00, 1'b0));
      send_scan(make_scan(MODE_TICK, 6'd0, 1'b0, OFF_SENSE, 8'h00, 1'b0));
      send_scan(make_scan(MODE_TICK, 6'd0, 1'b0, OFF_SENSE, 8'h00, 1'b1));
      send_scan(make_scan(MODE_KEY, POWER_KEY, 1'b1, OFF_SENSE, 8'h00, 1'b0));
      send_scan(make_scan(MODE_KEY, 6'd0, 1'b1, OFF_SENSE, 8'h00, 1'b0));
      // acknowledge with nothing pending
      send_scan(make_scan(MODE_TICK, 6'd0, 1'b0, OFF_SENSE, 8'h00, 1'b1));
   endtask

   // lines 7..9 pulling sense bit 7 with every pin level set, then none
   task automatic test_pin_levels();
      settle();
      set_pins(3'b111);
      send_scan(make_scan(MODE_WRITE, '0, 1'b0, OFF_DRIVE_LO, 8'h80, 1'b0));
      send_scan(make_scan(MODE_READ, '0, 1'b0, OFF_SENSE, 8'h00, 1'b0));
      settle();
      set_pins(3'b000);
      send_scan(make_scan(MODE_WRITE, '0, 1'b0, OFF_DRIVE_LO, 8'h81, 1'b0));
   endtask

   // receiver holds off while words keep coming, so the request side stalls
   task automatic test_output_backpressure();
      int n;
      settle();
      @(negedge clock);
      hold_request = 300;
      @(posedge clock);
      burst_left = 16;
      for (n = 0; n < 12; n++) begin
         if (n % 2 == 0)
            send_scan(make_scan(MODE_KEY, 6'(n * 5), 1'b1, OFF_SENSE, 8'h00, 1'b0));
         else
            send_scan(make_scan(MODE_READ, '0, 1'b0, OFF_SENSE, 8'h00, 1'b0));
      end
   endtask

   // random traffic over several pin settings; even phases press within a
   // small pool of sense lines (sparse map, ghost paths), odd ones half the time
   task automatic test_random_traffic();
      logic [2:0] settings [5];
      scan_req_type w;
      int phase, n, pick;
      settings = '{3'b000, 3'b111, 3'b101, 3'b010, 3'b110};
      for (phase = 0; phase < 5; phase++) begin
         settle();
         set_pins(settings[phase]);
         @(posedge clock);
         for (n = 0; n < 330; n++) begin
            w = make_scan(MODE_KEY, 6'($urandom), 1'($urandom), 3'($urandom),
                          8'($urandom), 1'($urandom));
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
               w.mode = MODE_KEY;
               if (phase % 2 == 0 || $urandom_range(0, 1) == 0)
                  w.key_index[2:0] = 3'($urandom_range(0, 2));
               // mostly flip the key so the event takes effect
               w.key_down = ($urandom_range(0, 9) != 0) ? !pressed_keys[w.key_index]
                                                         : pressed_keys[w.key_index];
            end else if (pick < 65) begin
               w.mode = MODE_WRITE;
               if ($urandom_range(0, 9) != 0)
                  w.reg_offset = 3'($urandom_range(OFF_MASK_LO, OFF_DRIVE_HI));
               // keep drive lines live now and then
               if (w.reg_offset == OFF_MASK_LO && $urandom_range(0, 1) == 0)
                  w.write_byte = '0;
            end else if (pick < 85) begin
               w.mode = MODE_READ;
               if ($urandom_range(0, 1) == 0) w.reg_offset = OFF_SENSE;
            end else begin
               w.mode = MODE_TICK;
            end
            send_scan(w);
         end
      end
   endtask

   initial begin
      int i;
      for (i = 0; i < 8; i++) begin
         line_group[i]    = '0;
         line_group[i][i] = 1'b1;
      end
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_register_map();
      test_key_events();
      test_pin_levels();
      test_output_backpressure();
      test_random_traffic();

      settle();
      repeat (20) @(posedge clock);
      if (scan_reports_q.size() != 0)
         report_mismatch("words never returned", 24'(scan_reports_q.size()), '0);
      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

@@ key_matrix_scan_with_ghosting.f @@
+incdir+rtl
rtl/kms_pkg.sv
rtl/kms_ghost_unit.sv
rtl/key_matrix_scan_with_ghosting.sv
tb/sv/key_matrix_scan_with_ghosting_test.sv
